>>> rtl/core/fec_pkg.sv
// Shared types, codes and widths for the free extent coalescer.
`default_nettype none

package fec_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_ADDR_BITS   = 16;

    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int BSIZE_W  = 16;
    localparam int SIZE_W   = 17;
    localparam int CMD_W    = 3;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP    = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_ENTRY = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef logic [CMD_W-1:0] t_cell_cmd;

    localparam t_cell_cmd CMD_KEEP       = 3'd0;
    localparam t_cell_cmd CMD_TAKE_LEFT  = 3'd1;
    localparam t_cell_cmd CMD_TAKE_NEW   = 3'd2;
    localparam t_cell_cmd CMD_SET_RIGHT  = 3'd3;
    localparam t_cell_cmd CMD_GROW       = 3'd4;
    localparam t_cell_cmd CMD_MERGE      = 3'd5;
    localparam t_cell_cmd CMD_TAKE_RIGHT = 3'd6;

    typedef struct packed {
        logic occ;
        logic le_l;
        logic cov_l;
        logic le_r;
        logic cov_r;
        logic eq_r;
        logic end_eq;
        logic stop;
    } t_cell_flags;

    typedef struct packed {
        logic full;
        logic cnt_inc;
        logic cnt_dec;
    } t_decision;

endpackage

`default_nettype wire

>>> rtl/core/fec_cell.sv
// One table cell: holds an extent, compares it against the current beat, updates from neighbors.
`default_nettype none

module fec_cell
    import fec_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_occ,
    input  wire [ADDR_BITS-1:0]     i_blk_start,
    input  wire [BSIZE_W-1:0]       i_blk_size,
    input  wire [ADDR_BITS-1:0]     i_left_start,
    input  wire [SIZE_W-1:0]        i_left_size,
    input  wire [ADDR_BITS-1:0]     i_right_start,
    input  wire [SIZE_W-1:0]        i_right_size,
    input  t_cell_cmd               i_cmd,
    input  wire                     i_apply,
    output logic [ADDR_BITS-1:0]    o_start,
    output logic [SIZE_W-1:0]       o_size,
    output t_cell_flags             o_flags
);

    localparam int EW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

    logic [ADDR_BITS-1:0] r_start;
    logic [SIZE_W-1:0]    r_size;
    logic [SIZE_W-1:0]    r_sum2;
    logic [SIZE_W-1:0]    r_sum3;
    t_cell_flags          r_flags;

    logic [EW-1:0]        cell_end;
    logic [EW-1:0]        addr_l;
    logic [EW-1:0]        addr_r;
    logic [SIZE_W:0]      sum2_raw;
    logic [SIZE_W+1:0]    sum3_raw;
    t_cell_flags          n_flags;
    logic [SIZE_W-1:0]    n_sum2;
    logic [SIZE_W-1:0]    n_sum3;

    always_comb begin
        cell_end = EW'(r_start) + EW'(r_size);
        addr_l   = EW'(i_blk_start - ADDR_BITS'(1));
        addr_r   = EW'(i_blk_start) + EW'(i_blk_size);

        n_flags.occ    = i_occ;
        n_flags.le_l   = i_occ && (EW'(r_start) <= addr_l);
        n_flags.cov_l  = addr_l < cell_end;
        n_flags.le_r   = i_occ && (EW'(r_start) <= addr_r);
        n_flags.cov_r  = addr_r < cell_end;
        n_flags.eq_r   = i_occ && (EW'(r_start) == addr_r);
        n_flags.end_eq = i_occ && (cell_end == EW'(i_blk_start));
        n_flags.stop   = !i_occ || !(r_start < i_blk_start);

        sum2_raw = (SIZE_W+1)'(r_size) + (SIZE_W+1)'(i_blk_size);
        sum3_raw = (SIZE_W+2)'(r_size) + (SIZE_W+2)'(i_blk_size)
                 + (SIZE_W+2)'(i_right_size);
        n_sum2   = (sum2_raw > (SIZE_W+1)'(SIZE_MAX)) ? SIZE_MAX : sum2_raw[SIZE_W-1:0];
        n_sum3   = (sum3_raw > (SIZE_W+2)'(SIZE_MAX)) ? SIZE_MAX : sum3_raw[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
        r_sum2  <= n_sum2;
        r_sum3  <= n_sum3;
        if (i_apply) begin
            case (i_cmd)
                CMD_TAKE_LEFT: begin
                    r_start <= i_left_start;
                    r_size  <= i_left_size;
                end
                CMD_TAKE_NEW: begin
                    r_start <= i_blk_start;
                    r_size  <= SIZE_W'(i_blk_size);
                end
                CMD_SET_RIGHT: begin
                    r_start <= i_blk_start;
                    r_size  <= r_sum2;
                end
                CMD_GROW: begin
                    r_size <= r_sum2;
                end
                CMD_MERGE: begin
                    r_size <= r_sum3;
                end
                CMD_TAKE_RIGHT: begin
                    r_start <= i_right_start;
                    r_size  <= i_right_size;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_start = r_start;
    assign o_size  = r_size;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

>>> rtl/core/fec_decide.sv
// Reduces the registered cell flags to a table operation and one command per cell.
`default_nettype none

module fec_decide
    import fec_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  t_cell_flags         i_flags [TABLE_DEPTH],
    input  wire [OP_W-1:0]      i_op,
    input  wire                 i_start_nz,
    input  wire                 i_full,
    output t_cell_cmd           o_cmd [TABLE_DEPTH],
    output t_decision           o_dec
);

    logic [TABLE_DEPTH-1:0] occ, le_l, cov_l, le_r, cov_r, eq_r, end_eq, stop;
    logic [TABLE_DEPTH-1:0] above_l, above_r, below_eqr, below_end, below_stop;
    logic [TABLE_DEPTH-1:0] first_eqr, first_end, ins_pos;
    logic                   l_free, r_free, has_next;
    logic                   m_insert, m_right, m_grow, m_merge;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            occ[i]    = i_flags[i].occ;
            le_l[i]   = i_flags[i].le_l;
            cov_l[i]  = i_flags[i].cov_l;
            le_r[i]   = i_flags[i].le_r;
            cov_r[i]  = i_flags[i].cov_r;
            eq_r[i]   = i_flags[i].eq_r;
            end_eq[i] = i_flags[i].end_eq;
            stop[i]   = i_flags[i].stop;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            above_l[i]    = |(le_l >> (i + 1));
            above_r[i]    = |(le_r >> (i + 1));
            below_eqr[i]  = |(eq_r << (TABLE_DEPTH - i));
            below_end[i]  = |(end_eq << (TABLE_DEPTH - i));
            below_stop[i] = |(stop << (TABLE_DEPTH - i));
        end
        first_eqr = eq_r & ~below_eqr;
        first_end = end_eq & ~below_end;
        ins_pos   = stop & ~below_stop;

        // The covering test uses only the last entry that starts at or below the address.
        l_free   = i_start_nz && (|(le_l & cov_l & ~above_l));
        r_free   = |(le_r & cov_r & ~above_r);
        has_next = |((first_end << 1) & occ);

        m_insert = 1'b0;
        m_right  = 1'b0;
        m_grow   = 1'b0;
        m_merge  = 1'b0;
        if (i_op != OP_RELEASE || (!l_free && !r_free)) begin
            m_insert = 1'b1;
        end else if (!l_free) begin
            m_right  = |eq_r;
            m_insert = !(|eq_r);
        end else if (|end_eq) begin
            m_merge = r_free && has_next;
            m_grow  = !(r_free && has_next);
        end else begin
            m_insert = 1'b1;
        end

        o_dec.full    = m_insert && i_full;
        o_dec.cnt_inc = m_insert && !i_full;
        o_dec.cnt_dec = m_merge;

        for (int i = 0; i < TABLE_DEPTH; i++) begin
            o_cmd[i] = CMD_KEEP;
            if (m_insert && !i_full) begin
                if (below_stop[i]) begin
                    o_cmd[i] = CMD_TAKE_LEFT;
                end else if (ins_pos[i]) begin
                    o_cmd[i] = CMD_TAKE_NEW;
                end
            end else if (m_right && first_eqr[i]) begin
                o_cmd[i] = CMD_SET_RIGHT;
            end else if (m_grow && first_end[i]) begin
                o_cmd[i] = CMD_GROW;
            end else if (m_merge) begin
                if (first_end[i]) begin
                    o_cmd[i] = CMD_MERGE;
                end else if (below_end[i]) begin
                    o_cmd[i] = CMD_TAKE_RIGHT;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/free_extent_coalescer.sv
// Top level of the free extent coalescer: control, cell row, dump scan and result register.
// Add and release take a compare step, where every cell compares its extent, then an update
// step, in which the row shifts or merges; the next beat is taken in the update step once the
// result register can accept. A dump takes the compare step, then walks the table one entry
// at a time, waiting while the result register is full, then closes; the next beat is taken
// in the idle state after that. Results are registered from the update or scan step.
// Synchronous active-low reset empties the table and clears control; cell contents are kept.
`default_nettype none

module free_extent_coalescer
    import fec_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire [OP_W-1:0]          i_opcode,
    input  wire [ADDR_BITS-1:0]     i_block_start,
    input  wire [BSIZE_W-1:0]       i_block_size,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic [ADDR_BITS-1:0]    o_entry_start,
    output logic [SIZE_W-1:0]       o_entry_size,
    output logic                    o_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_DUMP   = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [OP_W-1:0]      r_op;
    logic [ADDR_BITS-1:0] r_start;
    logic [BSIZE_W-1:0]   r_size;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend_valid, n_pend_valid;
    logic [ADDR_BITS-1:0] r_pend_start, n_pend_start;
    logic [SIZE_W-1:0]    r_pend_size, n_pend_size;
    logic                 r_out_valid;
    logic [ST_W-1:0]      r_out_status;
    logic [ADDR_BITS-1:0] r_out_start;
    logic [SIZE_W-1:0]    r_out_size;
    logic                 r_out_last;

    logic                 can_emit, in_fire, apply, emit;
    logic [ST_W-1:0]      e_status;
    logic [ADDR_BITS-1:0] e_start;
    logic [SIZE_W-1:0]    e_size;
    logic                 e_last;
    logic [ADDR_BITS-1:0] rd_start;
    logic [SIZE_W-1:0]    rd_size;

    logic [TABLE_DEPTH-1:0] occ;
    logic [ADDR_BITS-1:0]   cell_start [TABLE_DEPTH];
    logic [SIZE_W-1:0]      cell_size  [TABLE_DEPTH];
    t_cell_flags            cell_flags [TABLE_DEPTH];
    t_cell_cmd              cell_cmd   [TABLE_DEPTH];
    t_decision              dec;

    assign can_emit   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_UPDATE) && can_emit);
    assign in_fire    = i_in_valid && o_in_ready;
    assign apply      = (r_state == S_UPDATE) && can_emit;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic [ADDR_BITS-1:0] left_start, right_start;
            logic [SIZE_W-1:0]    left_size, right_size;

            assign occ[gi] = CW'(gi) < r_count;

            if (gi == 0) begin : g_first
                assign left_start = '0;
                assign left_size  = '0;
            end else begin : g_mid_l
                assign left_start = cell_start[gi-1];
                assign left_size  = cell_size[gi-1];
            end

            if (gi == TABLE_DEPTH - 1) begin : g_last
                assign right_start = '0;
                assign right_size  = '0;
            end else begin : g_mid_r
                assign right_start = cell_start[gi+1];
                assign right_size  = cell_size[gi+1];
            end

            fec_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_occ         (occ[gi]),
                .i_blk_start   (r_start),
                .i_blk_size    (r_size),
                .i_left_start  (left_start),
                .i_left_size   (left_size),
                .i_right_start (right_start),
                .i_right_size  (right_size),
                .i_cmd         (cell_cmd[gi]),
                .i_apply       (apply),
                .o_start       (cell_start[gi]),
                .o_size        (cell_size[gi]),
                .o_flags       (cell_flags[gi])
            );
        end
    endgenerate

    fec_decide #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_decide (
        .i_flags    (cell_flags),
        .i_op       (r_op),
        .i_start_nz (r_start != '0),
        .i_full     (r_count == CW'(TABLE_DEPTH)),
        .o_cmd      (cell_cmd),
        .o_dec      (dec)
    );

    assign rd_start = cell_start[r_idx[IW-1:0]];
    assign rd_size  = cell_size[r_idx[IW-1:0]];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_start = r_pend_start;
        n_pend_size  = r_pend_size;
        emit         = 1'b0;
        e_status     = ST_OK;
        e_start      = '0;
        e_size       = '0;
        e_last       = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_idx        = '0;
                n_pend_valid = 1'b0;
                if (r_op == OP_DUMP) begin
                    n_state = S_DUMP;
                end else if (r_op == OP_ADD || r_op == OP_RELEASE) begin
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UPDATE: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_status = dec.full ? ST_FULL : ST_OK;
                    if (dec.cnt_inc) begin
                        n_count = r_count + CW'(1);
                    end else if (dec.cnt_dec) begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = in_fire ? S_EVAL : S_IDLE;
                end
            end
            S_DUMP: begin
                if (r_idx < r_count) begin
                    if (rd_size == '0) begin
                        n_idx = r_idx + CW'(1);
                    end else if (!r_pend_valid) begin
                        n_pend_valid = 1'b1;
                        n_pend_start = rd_start;
                        n_pend_size  = rd_size;
                        n_idx        = r_idx + CW'(1);
                    end else if (can_emit) begin
                        emit         = 1'b1;
                        e_status     = ST_ENTRY;
                        e_start      = r_pend_start;
                        e_size       = r_pend_size;
                        e_last       = 1'b0;
                        n_pend_start = rd_start;
                        n_pend_size  = rd_size;
                        n_idx        = r_idx + CW'(1);
                    end
                end else if (can_emit) begin
                    // The held entry is the final listed one, or nothing was listed at all.
                    emit     = 1'b1;
                    e_status = r_pend_valid ? ST_ENTRY : ST_EMPTY;
                    e_start  = r_pend_valid ? r_pend_start : '0;
                    e_size   = r_pend_valid ? r_pend_size : '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_start <= n_pend_start;
        r_pend_size  <= n_pend_size;
        if (in_fire) begin
            r_op    <= i_opcode;
            r_start <= i_block_start;
            r_size  <= i_block_size;
        end
        if (emit) begin
            r_out_status <= e_status;
            r_out_start  <= e_start;
            r_out_size   <= e_size;
            r_out_last   <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_start = r_out_start;
    assign o_entry_size  = r_out_size;
    assign o_last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("extent count above table depth");

    a_update_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && can_emit) |=> r_out_valid)
        else $error("update step did not produce a result");

    a_dump_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_idx <= r_count))
        else $error("dump index ran past the table fill");

    a_count_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPDATE) |=> $stable(r_count))
        else $error("extent count changed outside an update step");

    a_no_accept_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP || r_state == S_EVAL) |-> !o_in_ready)
        else $error("input beat taken while a dump or compare is in progress");

endmodule

`default_nettype wire
